FILE: sv/oets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_pkg: shared types and constants of the odd-even transposition sorter
// Widths of key and tag, store capacity, queue geometry and the back-end
// state encoding.
// ----------------------------------------------------------------------------
package oets_pkg;

	// field widths
	localparam int KEY_W    = 16;
	localparam int TAG_W    = 10;

	// sort store geometry
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	// decoupling queue geometry (depth is a power of two)
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// one classified beat travelling from front to back
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             keep;
	} oets_item_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ODD,
		ST_EVEN,
		ST_EMIT
	} oets_state_t;

	// back-end status seen by the top level
	typedef struct packed {
		logic             loading;
		logic             emitting;
		logic [CNT_W-1:0] fill;
	} oets_sts_t;

endpackage

FILE: sv/oets_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_front: input acceptance and classification
// Counts beats of the current batch, marks beats past the store capacity as
// not kept and discards such beats unless they close the batch.
// ----------------------------------------------------------------------------
module oets_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [oets_pkg::KEY_W-1:0] key,
	input  logic [oets_pkg::TAG_W-1:0] tag,
	input  logic                     last,
	input  logic                     q_full,
	output logic                     q_push,
	output oets_pkg::oets_item_t     q_item
);
	import oets_pkg::*;

	logic [CNT_W-1:0] batch_cnt_q;
	logic             accept;
	logic             keep;

	// accept whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign keep     = (batch_cnt_q < CNT_W'(CAPACITY));

	// classified beat towards the queue
	assign q_push      = accept && (keep || last);
	assign q_item.key  = key;
	assign q_item.tag  = tag;
	assign q_item.last = last;
	assign q_item.keep = keep;

	// beats seen in the current batch, saturating at capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				batch_cnt_q <= '0;
			end else if (keep) begin
				batch_cnt_q <= batch_cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/oets_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_queue: short fifo between front and back
// Lets the front keep taking beats while the back is busy with a batch.
// ----------------------------------------------------------------------------
module oets_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  oets_pkg::oets_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 vld,
	output oets_pkg::oets_item_t pop_item
);
	import oets_pkg::*;

	oets_item_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign vld      = (cnt_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && vld;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/oets_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_back: sort store, transposition phases and emission
// A row of compare-swap cells loads the batch, runs one odd or even phase per
// cycle until a round makes no swap, then shifts the batch out from entry 0.
// ----------------------------------------------------------------------------
module oets_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_vld,
	input  oets_pkg::oets_item_t       q_item,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [oets_pkg::KEY_W-1:0] sorted_key,
	output logic [oets_pkg::TAG_W-1:0] sorted_tag,
	output logic                       final_res,
	output oets_pkg::oets_sts_t        sts
);
	import oets_pkg::*;

	oets_state_t      state_q;
	oets_state_t      state_d;

	logic [KEY_W-1:0] key_q [CAPACITY];
	logic [TAG_W-1:0] tag_q [CAPACITY];
	logic [KEY_W-1:0] key_d [CAPACITY];
	logic [TAG_W-1:0] tag_d [CAPACITY];

	logic [CNT_W-1:0] fill_q;
	logic             swap_seen_q;
	logic             out_vld_q;
	logic [KEY_W-1:0] out_key_q;
	logic [TAG_W-1:0] out_tag_q;
	logic             out_fin_q;

	logic [CAPACITY-2:0] swp;
	logic             swap_any;
	logic             sort_en;
	logic             odd_ph;
	logic             load_we;
	logic             emit_ld;
	logic             clr_seen;

	// compare-swap decisions for the active phase
	assign sort_en  = (state_q == ST_ODD) || (state_q == ST_EVEN);
	assign odd_ph   = (state_q == ST_ODD);
	assign swap_any = |swp;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_we  = 1'b0;
		emit_ld  = 1'b0;
		clr_seen = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				q_pop   = q_vld;
				load_we = q_vld && q_item.keep;
				if (q_vld && q_item.last) begin
					state_d  = ST_ODD;
					clr_seen = 1'b1;
				end
			end
			ST_ODD: begin
				state_d = ST_EVEN;
			end
			ST_EVEN: begin
				clr_seen = 1'b1;
				if (swap_seen_q || swap_any) begin
					state_d = ST_ODD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit_ld = !out_vld_q || !out_stall;
				if (emit_ld && (fill_q == CNT_W'(1))) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// next contents of the cell row
	always_comb begin
		key_d = key_q;
		tag_d = tag_q;
		swp   = '0;
		for (int i = 0; i < CAPACITY - 1; i++) begin
			swp[i] = sort_en && (((i % 2) == 1) == odd_ph) &&
				(CNT_W'(i + 2) <= fill_q) && (key_q[i] > key_q[i + 1]);
		end
		if (sort_en) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (swp[i]) begin
					key_d[i]     = key_q[i + 1];
					tag_d[i]     = tag_q[i + 1];
					key_d[i + 1] = key_q[i];
					tag_d[i + 1] = tag_q[i];
				end
			end
		end else if (emit_ld) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				key_d[i] = key_q[i + 1];
				tag_d[i] = tag_q[i + 1];
			end
		end else if (load_we) begin
			key_d[fill_q[IDX_W-1:0]] = q_item.key;
			tag_d[fill_q[IDX_W-1:0]] = q_item.tag;
		end
	end

	// cell row registers
	always_ff @(posedge clk) begin
		key_q <= key_d;
		tag_q <= tag_d;
	end

	// fill count and round swap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			swap_seen_q <= 1'b0;
		end else begin
			if (load_we) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (emit_ld) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (clr_seen) begin
				swap_seen_q <= 1'b0;
			end else if (swap_any) begin
				swap_seen_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_ld) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ld) begin
			out_key_q <= key_q[0];
			out_tag_q <= tag_q[0];
			out_fin_q <= (fill_q == CNT_W'(1));
		end
	end

	assign out_valid    = out_vld_q;
	assign sorted_key   = out_key_q;
	assign sorted_tag   = out_tag_q;
	assign final_res    = out_fin_q;
	assign sts.loading  = (state_q == ST_LOAD);
	assign sts.emitting = (state_q == ST_EMIT);
	assign sts.fill     = fill_q;

endmodule

FILE: sv/odd_even_transposition_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sort: batch sorter by key, stable, with tag payload
//
//   channel | handshake            | beat fields
//   --------+----------------------+------------------------------------
//   in      | in_valid / in_stall  | key, tag, last
//   out     | out_valid / out_stall| sorted_key, sorted_tag, final_res
//
// Loading takes one beat per cycle through a two-entry queue.
// Sorting runs one phase per cycle, an odd and an even phase per round, until
// a round makes no swap.
// Emission gives one beat per cycle from the output register when not stalled;
// in_stall rises while the back end sorts or emits and the queue fills up.
// Reset empties the queue and the store; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [oets_pkg::KEY_W-1:0] key,
	input  logic [oets_pkg::TAG_W-1:0] tag,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [oets_pkg::KEY_W-1:0] sorted_key,
	output logic [oets_pkg::TAG_W-1:0] sorted_tag,
	output logic                       final_res
);
	import oets_pkg::*;

	logic       q_full;
	logic       q_push;
	oets_item_t push_item;
	logic       q_pop;
	logic       q_vld;
	oets_item_t pop_item;
	oets_sts_t  sts;

	// front: accept and classify beats
	oets_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.key      (key),
		.tag      (tag),
		.last     (last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// decoupling queue
	oets_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.vld       (q_vld),
		.pop_item  (pop_item)
	);

	// back: store, sort and emit
	oets_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_vld      (q_vld),
		.q_item     (pop_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sorted_key (sorted_key),
		.sorted_tag (sorted_tag),
		.final_res  (final_res),
		.sts        (sts)
	);

`ifndef SYNTH
	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue overflow");

	// the store never holds more than its capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.fill <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	// beats leave the queue only while the back end is loading
	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> sts.loading)
		else $error("queue popped outside loading");

	// a result appears only after the back end was emitting
	a_out_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(sts.emitting))
		else $error("result outside emission");
`endif

endmodule
